// ===== hdl/smb_pkg.sv =====
// Shared constants, types and register codes of the spectrum meter ballistics block.
package smb_pkg;

  localparam int NUM_BINS  = 64;
  localparam int BASS_BINS = 8;

  localparam int BIN_W   = 6;
  localparam int LVL_W   = 16;
  localparam int SUM_W   = 19;
  localparam int FLASH_W = 8;
  localparam int PROD_W  = 2 * LVL_W;
  localparam int RAM_W   = 3 * LVL_W;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (LVL_W - 1);

  // Stream widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_ACCEL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_RATIO     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_FLOOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_FRAMES   = 3'd6;

  // Input function codes.
  localparam logic FUNC_BIN   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic [LVL_W-1:0]   rise_gain;
    logic [LVL_W-1:0]   fall_gain;
    logic [LVL_W-1:0]   peak_accel;
    logic [LVL_W-1:0]   average_weight;
    logic [LVL_W-1:0]   beat_ratio;
    logic [LVL_W-1:0]   beat_floor;
    logic [FLASH_W-1:0] flash_frames;
  } smb_cfg_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_in;
    logic clear_pk;
    logic mul_ease;
    logic upd_shown;
    logic upd_peak;
    logic mul_avg;
    logic upd_avg;
    logic mul_beat;
    logic upd_beat;
    logic load_out;
  } smb_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic in_clear;
    logic in_range;
    logic last;
    logic out_free;
  } smb_stat_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_STEP = 9'b000000100,
    S_PEAK = 9'b000001000,
    S_AMUL = 9'b000010000,
    S_AUPD = 9'b000100000,
    S_BMUL = 9'b001000000,
    S_BEAT = 9'b010000000,
    S_OUT  = 9'b100000000
  } smb_state_t;

endpackage

// ===== hdl/spectrum_meter_ballistics.sv =====
// Top level of the spectrum meter ballistics block: configuration registers, controller, datapath.
// A bin result passes through the states MUL, STEP and PEAK (and AMUL, AUPD, BMUL and BEAT on the last bin)
// before S_OUT loads the output register, waiting there while it is not free; a new bin waits until then.
// A clear item leaves the input open. The sequence follows the bin RAM read-modify-write and the one shared multiplier.
// Reset (synchronous, rst_n low) zeroes all bin levels, peaks and speeds through valid bits at once,
// clears the bass state and restores the default register values; no clearing pass is needed.
module spectrum_meter_ballistics import smb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [5:0] bin_index, [21:6] level, [23:22] zero
  input  logic                   in_tuser,   // [0] func
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [5:0] out_bin, [21:6] shown_level,
                                             // [37:22] peak_level, [39:38] zero
  output logic                   out_tlast,  // frame_end
  output logic                   out_tuser,  // [0] beat_active
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [LVL_W-1:0]       cfg_data
);

  smb_cfg_t  cfg_r;
  smb_cmd_t  cmd;
  smb_stat_t stat;

  // Registers take a write in any cycle; the user must write only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_gain      <= 16'd26214;
      cfg_r.fall_gain      <= 16'd16384;
      cfg_r.peak_accel     <= 16'd393;
      cfg_r.average_weight <= 16'd3277;
      cfg_r.beat_ratio     <= 16'd5734;
      cfg_r.beat_floor     <= 16'd26214;
      cfg_r.flash_frames   <= 8'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RISE_GAIN:      cfg_r.rise_gain      <= cfg_data;
        REG_FALL_GAIN:      cfg_r.fall_gain      <= cfg_data;
        REG_PEAK_ACCEL:     cfg_r.peak_accel     <= cfg_data;
        REG_AVERAGE_WEIGHT: cfg_r.average_weight <= cfg_data;
        REG_BEAT_RATIO:     cfg_r.beat_ratio     <= cfg_data;
        REG_BEAT_FLOOR:     cfg_r.beat_floor     <= cfg_data;
        REG_FLASH_FRAMES:   cfg_r.flash_frames   <= cfg_data[FLASH_W-1:0];
        default: begin
          // Drop writes to unknown indexes.
        end
      endcase
    end
  end

  // Sequence each bin through read, ease, peak/write and, on the last bin, the frame work.
  smb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the bin memory, arithmetic and the output register.
  smb_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg_r),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A beat flag only ever rides on the last bin of a frame.
  a_beat_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("beat flag without frame end");

  // The frame end marks the highest bin.
  a_frame_end_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[BIN_W-1:0] == BIN_W'(NUM_BINS - 1)))
    else $error("frame end on wrong bin");

  // A clear transfer finishes at once and leaves the input open.
  a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FUNC_CLEAR)) |=> in_tready)
    else $error("clear transfer stalled input");

  // A bin transfer starts the update sequence and closes the input.
  a_bin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FUNC_BIN)
      && (32'(in_tdata[BIN_W-1:0]) < NUM_BINS)) |=> !in_tready)
    else $error("input open during bin update");

endmodule

// ===== hdl/smb_ram.sv =====
// Generic single-port-write, registered-read RAM.
module smb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/smb_ctrl.sv =====
// Controller state machine sequencing one bin update and the frame-end work.
module smb_ctrl import smb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  smb_stat_t stat,
  output smb_cmd_t  cmd
);

  smb_state_t state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_in  = accept;
        cmd.clear_pk = accept & stat.in_clear;
        if (accept && !stat.in_clear && stat.in_range) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_ease = 1'b1;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        cmd.upd_shown = 1'b1;
        state_nxt     = S_PEAK;
      end
      S_PEAK: begin
        cmd.upd_peak = 1'b1;
        state_nxt    = stat.last ? S_AMUL : S_OUT;
      end
      S_AMUL: begin
        cmd.mul_avg = 1'b1;
        state_nxt   = S_AUPD;
      end
      S_AUPD: begin
        cmd.upd_avg = 1'b1;
        state_nxt   = S_BMUL;
      end
      S_BMUL: begin
        cmd.mul_beat = 1'b1;
        state_nxt    = S_BEAT;
      end
      S_BEAT: begin
        cmd.upd_beat = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/smb_dpath.sv =====
// Datapath: bin memory, shared multiplier, easing, peak hold, bass average and output register.
module smb_dpath import smb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  smb_cmd_t               cmd,
  output smb_stat_t              stat,
  input  smb_cfg_t               cfg,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  logic [BIN_W-1:0] in_bin;
  logic [LVL_W-1:0] in_level;

  logic [BIN_W-1:0] bin_r;
  logic [LVL_W-1:0] level_r;
  logic [NUM_BINS-1:0] shown_vld_r, pk_vld_r;

  logic             ram_we;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  logic [LVL_W-1:0] shown_old, peak_old, speed_old;
  logic             rising_r, rising;
  logic [LVL_W-1:0] gain, diff;
  logic [LVL_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod_r, prod_rnd;
  logic [LVL_W-1:0] step;
  logic [LVL_W-1:0] shown_new_r, peak_new_r;
  logic [LVL_W-1:0] peak_calc, speed_calc;
  logic [LVL_W:0]   speed_sum;

  logic [SUM_W-1:0] bass_sum_r, sum_base, sum_calc;
  logic [SUM_W:0]   sum_ext;
  logic             bass_bin, last;

  logic [LVL_W-1:0] mean, mean_r, avg_r, avg_diff;
  logic             avg_up;
  logic [FLASH_W-1:0] flash_r, flash_nxt;
  logic [PROD_W-1:0] mean_scaled;
  logic             beat, beat_r;

  logic                  out_tvalid_r;
  logic [BIN_W-1:0]      out_bin_r;
  logic [LVL_W-1:0]      out_shown_r, out_peak_r;
  logic                  out_last_r, out_beat_r;

  // Unpack the incoming item.
  assign in_bin   = in_tdata[BIN_W-1:0];
  assign in_level = in_tdata[BIN_W+LVL_W-1:BIN_W];

  assign stat.in_clear = (in_tuser == FUNC_CLEAR);
  assign stat.in_range = (32'(in_bin) < NUM_BINS);
  assign last          = (bin_r == BIN_W'(NUM_BINS - 1));
  assign stat.last     = last;
  assign stat.out_free = !out_tvalid_r || out_tready;

  // One word per bin: {speed, peak, shown}.
  smb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bin_r),
    .wdata (ram_wdata),
    .re    (cmd.load_in),
    .raddr (in_bin),
    .rdata (ram_rdata)
  );

  // Entries never written since reset read as zero; after a clear, peaks and speeds do too.
  assign shown_old = shown_vld_r[bin_r] ? ram_rdata[LVL_W-1:0] : '0;
  assign peak_old  = pk_vld_r[bin_r] ? ram_rdata[2*LVL_W-1:LVL_W] : '0;
  assign speed_old = pk_vld_r[bin_r] ? ram_rdata[3*LVL_W-1:2*LVL_W] : '0;

  // Easing of the shown level.
  assign rising = (level_r > shown_old);
  assign gain   = rising ? cfg.rise_gain : cfg.fall_gain;
  assign diff   = rising ? (level_r - shown_old) : (shown_old - level_r);

  // Frame mean and its easing into the running average.
  assign mean     = LVL_W'(bass_sum_r / BASS_BINS);
  assign avg_up   = (mean > avg_r);
  assign avg_diff = avg_up ? (mean - avg_r) : (avg_r - mean);

  // Shared multiplier operand select.
  always_comb begin
    mul_a = diff;
    mul_b = gain;
    if (cmd.mul_avg) begin
      mul_a = avg_diff;
      mul_b = cfg.average_weight;
    end else if (cmd.mul_beat) begin
      mul_a = avg_r;
      mul_b = cfg.beat_ratio;
    end
  end

  assign prod_rnd = prod_r + ROUND_HALF;
  assign step     = prod_rnd[PROD_W-1:LVL_W];

  // Peak hold with accelerating fall.
  assign speed_sum = (LVL_W+1)'(speed_old) + (LVL_W+1)'(cfg.peak_accel);
  always_comb begin
    if (shown_new_r > peak_old) begin
      peak_calc  = shown_new_r;
      speed_calc = '0;
    end else begin
      speed_calc = speed_sum[LVL_W] ? {LVL_W{1'b1}} : speed_sum[LVL_W-1:0];
      peak_calc  = (peak_old > speed_calc) ? (peak_old - speed_calc) : '0;
    end
  end

  assign ram_we    = cmd.upd_peak;
  assign ram_wdata = {speed_calc, peak_calc, shown_new_r};

  // Bass sum, restarted at bin zero, saturating.
  assign bass_bin = (32'(bin_r) < BASS_BINS);
  assign sum_base = (bin_r == '0) ? '0 : bass_sum_r;
  assign sum_ext  = (SUM_W+1)'(sum_base) + (SUM_W+1)'(level_r);
  assign sum_calc = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

  // Beat test against the updated average.
  assign mean_scaled = PROD_W'(mean_r) << 12;
  assign beat        = (mean_scaled > prod_r) && (mean_r > cfg.beat_floor);
  always_comb begin
    flash_nxt = flash_r;
    if (beat) begin
      flash_nxt = cfg.flash_frames;
    end else if (flash_r != '0) begin
      flash_nxt = flash_r - FLASH_W'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bin_r   <= in_bin;
      level_r <= in_level;
    end
    if (cmd.mul_ease || cmd.mul_avg || cmd.mul_beat) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.mul_ease) begin
      rising_r <= rising;
    end
    if (cmd.mul_avg) begin
      mean_r   <= mean;
      rising_r <= avg_up;
    end
    if (cmd.upd_shown) begin
      shown_new_r <= rising_r ? (shown_old + step) : (shown_old - step);
    end
    if (cmd.upd_peak) begin
      peak_new_r <= peak_calc;
    end
    if (cmd.upd_beat) begin
      beat_r <= (flash_nxt != '0);
    end
    if (cmd.load_out) begin
      out_bin_r   <= bin_r;
      out_shown_r <= shown_new_r;
      out_peak_r  <= peak_new_r;
      out_last_r  <= last;
      out_beat_r  <= last & beat_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_vld_r  <= '0;
      pk_vld_r     <= '0;
      bass_sum_r   <= '0;
      avg_r        <= '0;
      flash_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.clear_pk) begin
        pk_vld_r <= '0;
      end
      if (cmd.upd_peak) begin
        shown_vld_r[bin_r] <= 1'b1;
        pk_vld_r[bin_r]    <= 1'b1;
        if (bass_bin) begin
          bass_sum_r <= sum_calc;
        end else if (bin_r == '0) begin
          bass_sum_r <= '0;
        end
      end
      if (cmd.upd_avg) begin
        avg_r <= rising_r ? (avg_r + step) : (avg_r - step);
      end
      if (cmd.upd_beat) begin
        flash_r    <= flash_nxt;
        bass_sum_r <= '0;
      end
      if (cmd.load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_peak_r, out_shown_r, out_bin_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_beat_r;

endmodule

// ===== tb/smb_meter_sb_pkg.sv =====
// Bin result type and the meter scoreboard that predicts and checks bin results.
package smb_meter_sb_pkg;
  import smb_pkg::*;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [LVL_W-1:0] shown;
    logic [LVL_W-1:0] peak;
    logic             frame_end;
    logic             beat;
  } bin_result_t;

  class meter_scoreboard;
    smb_cfg_t           regs;
    logic [LVL_W-1:0]   shown_lvl  [NUM_BINS];
    logic [LVL_W-1:0]   peak_lvl   [NUM_BINS];
    logic [LVL_W-1:0]   fall_speed [NUM_BINS];
    logic [SUM_W-1:0]   bass_sum;
    logic [LVL_W-1:0]   low_band_avg;
    logic [FLASH_W-1:0] flash_cnt;
    bin_result_t        bin_results_due[$];
    int                 errors;

    function new();
      regs.rise_gain      = 16'd26214;
      regs.fall_gain      = 16'd16384;
      regs.peak_accel     = 16'd393;
      regs.average_weight = 16'd3277;
      regs.beat_ratio     = 16'd5734;
      regs.beat_floor     = 16'd26214;
      regs.flash_frames   = 8'd6;
      foreach (shown_lvl[i]) begin
        shown_lvl[i]  = '0;
        peak_lvl[i]   = '0;
        fall_speed[i] = '0;
      end
      bass_sum     = '0;
      low_band_avg = '0;
      flash_cnt    = '0;
      errors       = 0;
    endfunction

    // Move cur toward target by the rounded fraction gain of the distance.
    function logic [LVL_W-1:0] ease(input logic [LVL_W-1:0] cur,
                                    input logic [LVL_W-1:0] target,
                                    input logic [LVL_W-1:0] gain);
      logic [PROD_W:0] diff;
      logic [PROD_W:0] step;
      if (target > cur) begin
        diff = target - cur;
        step = diff * gain + ROUND_HALF;
        return cur + step[PROD_W-1:LVL_W];
      end
      diff = cur - target;
      step = diff * gain + ROUND_HALF;
      return cur - step[PROD_W-1:LVL_W];
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] data);
      case (idx)
        REG_RISE_GAIN:      regs.rise_gain      = data;
        REG_FALL_GAIN:      regs.fall_gain      = data;
        REG_PEAK_ACCEL:     regs.peak_accel     = data;
        REG_AVERAGE_WEIGHT: regs.average_weight = data;
        REG_BEAT_RATIO:     regs.beat_ratio     = data;
        REG_BEAT_FLOOR:     regs.beat_floor     = data;
        REG_FLASH_FRAMES:   regs.flash_frames   = data[FLASH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(input logic func, input logic [BIN_W-1:0] bin,
                             input logic [LVL_W-1:0] level);
      logic [LVL_W-1:0] shown;
      logic [LVL_W-1:0] peak;
      logic [LVL_W-1:0] gain;
      logic [LVL_W-1:0] mean;
      logic [LVL_W:0]   speed;
      logic [SUM_W:0]   sum;
      bin_result_t      res;
      if (func == FUNC_CLEAR) begin
        foreach (peak_lvl[i]) begin
          peak_lvl[i]   = '0;
          fall_speed[i] = '0;
        end
        return;
      end
      if (int'(bin) >= NUM_BINS) return;

      gain  = (level > shown_lvl[bin]) ? regs.rise_gain : regs.fall_gain;
      shown = ease(shown_lvl[bin], level, gain);
      peak  = peak_lvl[bin];
      speed = {1'b0, fall_speed[bin]};
      if (shown > peak) begin
        peak  = shown;
        speed = '0;
      end else begin
        speed = speed + regs.peak_accel;
        if (speed > 17'h0FFFF) speed = 17'h0FFFF;
        peak = (peak > speed[LVL_W-1:0]) ? peak - speed[LVL_W-1:0] : '0;
      end
      shown_lvl[bin]  = shown;
      peak_lvl[bin]   = peak;
      fall_speed[bin] = speed[LVL_W-1:0];

      if (bin == 0) bass_sum = '0;
      if (bin < BASS_BINS) begin
        sum      = {1'b0, bass_sum} + level;
        bass_sum = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
      end

      res.bin       = bin;
      res.shown     = shown;
      res.peak      = peak;
      res.frame_end = (int'(bin) == NUM_BINS - 1);
      res.beat      = 1'b0;
      if (res.frame_end) begin
        mean         = LVL_W'(bass_sum / BASS_BINS);
        low_band_avg = ease(low_band_avg, mean, regs.average_weight);
        if (64'(mean) * 64'd4096 > 64'(low_band_avg) * 64'(regs.beat_ratio) &&
            mean > regs.beat_floor)
          flash_cnt = regs.flash_frames;
        else if (flash_cnt != 0)
          flash_cnt = flash_cnt - 1'b1;
        bass_sum = '0;
        res.beat = (flash_cnt != 0);
      end
      bin_results_due = {bin_results_due, res};
    endfunction

    function void check_field(input string name, input int unsigned exp_v,
                              input int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(input bin_result_t got);
      bin_result_t want;
      if (bin_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual bin 0x%0h shown 0x%0h",
                 $time, got.bin, got.shown);
        errors++;
        return;
      end
      want = bin_results_due.pop_front();
      check_field("out_bin",     want.bin,       got.bin);
      check_field("shown_level", want.shown,     got.shown);
      check_field("peak_level",  want.peak,      got.peak);
      check_field("frame_end",   want.frame_end, got.frame_end);
      check_field("beat_active", want.beat,      got.beat);
    endfunction

    function int pending();
      return bin_results_due.size();
    endfunction
  endclass

endpackage

// ===== tb/spectrum_meter_ballistics_test.sv =====
// Top-level testbench of the spectrum meter ballistics block: stimulus, handshakes, checking.
module spectrum_meter_ballistics_test;
  timeunit 1ns;
  timeprecision 1ps;
  import smb_pkg::*;
  import smb_meter_sb_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Quiet cycles after the last result: covers the frame-end path and clears.
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 185;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [5:0] bin_index, [21:6] level, [23:22] zero
  logic                   in_tuser   = 1'b0; // [0] func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [5:0] out_bin, [21:6] shown_level,
                                            // [37:22] peak_level, [39:38] zero
  logic                   out_tlast;        // frame_end
  logic                   out_tuser;        // [0] beat_active
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [LVL_W-1:0]       cfg_data   = '0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;

  meter_scoreboard sb;

  spectrum_meter_ballistics u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: decide back-pressure for the next edge at each falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Result monitor and hang watchdog: sample everything at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(bin_result_t'({out_tdata[5:0], out_tdata[21:6], out_tdata[37:22],
                                     out_tlast, out_tuser}));
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one item: idle at random, then hold it until the transfer happens.
  task automatic send_item(input logic func, input logic [BIN_W-1:0] bin,
                           input logic [LVL_W-1:0] level);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {2'b00, level, bin};
    do @(posedge clk); while (!in_tready);
    sb.note_input(func, bin, level);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop the input valid, wait for every pending result, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LVL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return LVL_W'($urandom_range(0, 255));
      default: return LVL_W'($urandom);
    endcase
  endfunction

  // One frame of bins in ascending order; the bass bins follow a per-frame profile
  // so that loud bass after quiet frames can trigger beats. Skip a bin or slip in
  // a clear now and then.
  task automatic send_frame();
    int               bass_mode;
    logic [LVL_W-1:0] lvl;
    bass_mode = $urandom_range(0, 3);
    for (int b = 0; b < NUM_BINS; b++) begin
      if ($urandom_range(0, 99) < 2) continue;
      if ($urandom_range(0, 99) < 1)
        send_item(FUNC_CLEAR, BIN_W'($urandom), LVL_W'($urandom));
      lvl = pick_level();
      if (b < BASS_BINS) begin
        case (bass_mode)
          1: lvl = LVL_W'($urandom_range(50000, 65535));
          2: lvl = LVL_W'($urandom_range(0, 8000));
          default: ;
        endcase
      end
      send_item(FUNC_BIN, BIN_W'(b), lvl);
    end
  endtask

  // Noise: any bin in any order, with clears mixed in.
  task automatic send_noise();
    send_item(($urandom_range(0, 3) == 0) ? FUNC_CLEAR : FUNC_BIN,
              BIN_W'($urandom), pick_level());
  endtask

  // Write every register for a phase: defaults, both extremes, then random settings.
  task automatic set_config(input int phase);
    smb_cfg_t c;
    case (phase)
      0: c = {16'd26214, 16'd16384, 16'd393, 16'd3277, 16'd5734, 16'd26214, 8'd6};
      1: c = '1;
      2: c = '0;
      default: begin
        c.rise_gain      = LVL_W'($urandom);
        c.fall_gain      = LVL_W'($urandom);
        c.peak_accel     = ($urandom_range(0, 1) == 0) ? LVL_W'($urandom_range(0, 2000))
                                                       : LVL_W'($urandom);
        c.average_weight = LVL_W'($urandom);
        c.beat_ratio     = LVL_W'($urandom_range(0, 12000));
        c.beat_floor     = LVL_W'($urandom_range(0, 45000));
        c.flash_frames   = FLASH_W'($urandom_range(0, 12));
      end
    endcase
    write_reg(REG_RISE_GAIN,      c.rise_gain);
    write_reg(REG_FALL_GAIN,      c.fall_gain);
    write_reg(REG_PEAK_ACCEL,     c.peak_accel);
    write_reg(REG_AVERAGE_WEIGHT, c.average_weight);
    write_reg(REG_BEAT_RATIO,     c.beat_ratio);
    write_reg(REG_BEAT_FLOOR,     c.beat_floor);
    // Junk in the upper byte must not reach the flash length.
    write_reg(REG_FLASH_FRAMES,   {FLASH_W'($urandom), c.flash_frames});
    write_reg(REG_UNUSED,         LVL_W'($urandom));
  endtask

  initial begin
    int start;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset register values, no idling.
    // Fill the bass bins at full scale, then revisit two of them so the sum saturates.
    for (int b = 0; b < BASS_BINS; b++) send_item(FUNC_BIN, BIN_W'(b), '1);
    send_item(FUNC_BIN, BIN_W'(3), '1);
    send_item(FUNC_BIN, BIN_W'(5), '1);
    // Frame end with the middle bins missing: loud bass against a zero average.
    send_item(FUNC_BIN, BIN_W'(NUM_BINS - 1), '0);
    // Fall on bin 0 restarts the bass sum; then clear peaks and watch them restart.
    send_item(FUNC_BIN, BIN_W'(0), '0);
    send_item(FUNC_CLEAR, BIN_W'(NUM_BINS - 1), '1);
    send_item(FUNC_BIN, BIN_W'(0), '0);
    // Peak follows a rise, then falls with growing speed.
    send_item(FUNC_BIN, BIN_W'(32), '1);
    send_item(FUNC_BIN, BIN_W'(32), '1);
    send_item(FUNC_BIN, BIN_W'(32), '0);
    send_item(FUNC_BIN, BIN_W'(32), '0);
    send_item(FUNC_BIN, BIN_W'(32), '0);
    // Quiet frame end: flash counts down.
    send_item(FUNC_BIN, BIN_W'(NUM_BINS - 1), '1);
    send_item(FUNC_BIN, BIN_W'(NUM_BINS - 2), LVL_W'(1));

    // Random part: each phase has its own register setting and idling mix.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_config(p);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8)
          send_frame();
        else
          repeat ($urandom_range(1, 6)) send_noise();
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
